FILE: rtl/software_timer_bank_unit_macros.svh
// ----------------------------------------------------------------------------
// Timer bank assertion macros
// Shared property shapes for the timer bank checkers.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_UNIT_MACROS_SVH
`define SOFTWARE_TIMER_BANK_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define STB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define STB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Sizes, command and result codes, request and result types.
// ----------------------------------------------------------------------------
package stb_pkg;

	localparam int SLOTS      = 16;
	localparam int OWNER_BITS = 8;
	localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_BITS   = SLOT_BITS + 1;
	localparam int ID_BITS    = 5;
	localparam int TIME_BITS  = 32;

	localparam logic [2:0] CMD_START      = 3'd0;
	localparam logic [2:0] CMD_TICK       = 3'd1;
	localparam logic [2:0] CMD_STOP       = 3'd2;
	localparam logic [2:0] CMD_STOP_OWNER = 3'd3;
	localparam logic [2:0] CMD_QUERY      = 3'd4;

	localparam logic [2:0] KIND_START      = 3'd0;
	localparam logic [2:0] KIND_EXPIRY     = 3'd1;
	localparam logic [2:0] KIND_STOP       = 3'd2;
	localparam logic [2:0] KIND_STOP_OWNER = 3'd3;
	localparam logic [2:0] KIND_QUERY      = 3'd4;

	typedef struct packed {
		logic [2:0]           command;
		logic [7:0]           owner;
		logic [TIME_BITS-1:0] duration_us;
		logic [ID_BITS-1:0]   timer_id;
		logic [TIME_BITS-1:0] elapsed_us;
	} cmd_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic [ID_BITS-1:0]   result_id;
		logic [7:0]           result_owner;
		logic [TIME_BITS-1:0] remaining_us;
		logic                 ok;
		logic                 last;
	} rsp_t;

	// one slot as held in the memory
	typedef struct packed {
		logic [OWNER_BITS-1:0] owner;
		logic [TIME_BITS-1:0]  remaining;
	} entry_t;

	typedef struct packed {
		logic valid;
		rsp_t data;
	} rsp_push_t;

endpackage

FILE: rtl/software_timer_bank_unit.sv
// Start and stop answer in the exec state, query in the wait state after its read.
// Tick and stop-owner sweep the slot memory one slot per cycle through its single
// read port; a tick sweep holds while a second expiry waits on a stalled consumer.
// One request is in work at a time; the next is taken once the last result is queued.
// Reset clears the live bits and control; owner and time memory is not cleared.
// ----------------------------------------------------------------------------
// Timer bank top level
// Sequencer over a slot memory of owners and remaining times, live bits in flops.
// ----------------------------------------------------------------------------
module software_timer_bank_unit import stb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_QWAIT = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]            state_q, state_d;
	logic [SLOTS-1:0]      live_q, live_d;
	logic [CNT_BITS-1:0]   rd_idx_q, rd_idx_d;
	logic                  vld_s1, vld_s1_d;
	logic [SLOT_BITS-1:0]  idx_s1, idx_s1_d;
	logic                  pend_vld_q, pend_vld_d;
	logic [SLOT_BITS-1:0]  pend_idx_q, pend_idx_d;
	logic [OWNER_BITS-1:0] pend_owner_q, pend_owner_d;
	logic                  hit_q, hit_d;

	logic [2:0]            cmd_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [TIME_BITS-1:0]  duration_q;
	logic [ID_BITS-1:0]    id_q;
	logic [TIME_BITS-1:0]  elapsed_q;

	logic                  accept;
	logic                  free_found;
	logic [SLOT_BITS-1:0]  free_idx;
	logic                  id_ok;
	logic [SLOT_BITS-1:0]  id_slot;
	logic                  id_live;
	logic                  is_tick;
	logic                  s1_live;
	logic                  expire;
	logic                  stall_s1;

	logic                  ram_we;
	logic [SLOT_BITS-1:0]  ram_waddr;
	entry_t                ram_wdata;
	logic                  ram_re;
	logic [SLOT_BITS-1:0]  ram_raddr;
	entry_t                ram_rdata;

	rsp_push_t             push;
	logic                  can_push;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_BITS'(i);
			end
		end
	end

	assign id_ok   = (id_q != '0) && (32'(id_q) <= 32'(SLOTS));
	assign id_slot = SLOT_BITS'(id_q - ID_BITS'(1));
	assign id_live = id_ok && live_q[id_slot];

	assign is_tick  = (cmd_q == CMD_TICK);
	assign s1_live  = vld_s1 && live_q[idx_s1];
	assign expire   = (ram_rdata.remaining <= elapsed_q);
	// a second expiry must push the held one first
	assign stall_s1 = s1_live && is_tick && expire && pend_vld_q && !can_push;

	always_comb begin
		state_d      = state_q;
		live_d       = live_q;
		rd_idx_d     = rd_idx_q;
		vld_s1_d     = vld_s1;
		idx_s1_d     = idx_s1;
		pend_vld_d   = pend_vld_q;
		pend_idx_d   = pend_idx_q;
		pend_owner_d = pend_owner_q;
		hit_d        = hit_q;
		ram_we       = 1'b0;
		ram_waddr    = '0;
		ram_wdata    = '0;
		ram_re       = 1'b0;
		ram_raddr    = '0;
		push         = '0;
		push.data.last = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d    = ST_EXEC;
					pend_vld_d = 1'b0;
					hit_d      = 1'b0;
				end
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_START: begin
						if (can_push) begin
							push.valid     = 1'b1;
							push.data.kind = KIND_START;
							if (free_found) begin
								push.data.result_id = ID_BITS'(free_idx) + ID_BITS'(1);
								push.data.ok        = 1'b1;
								ram_we              = 1'b1;
								ram_waddr           = free_idx;
								ram_wdata.owner     = owner_q;
								ram_wdata.remaining = duration_q;
								live_d[free_idx]    = 1'b1;
							end
							state_d = ST_IDLE;
						end
					end
					CMD_TICK, CMD_STOP_OWNER: begin
						rd_idx_d = '0;
						vld_s1_d = 1'b0;
						state_d  = ST_SWEEP;
					end
					CMD_STOP: begin
						if (can_push) begin
							push.valid     = 1'b1;
							push.data.kind = KIND_STOP;
							if (id_live) begin
								push.data.result_id = id_q;
								push.data.ok        = 1'b1;
								live_d[id_slot]     = 1'b0;
							end
							state_d = ST_IDLE;
						end
					end
					CMD_QUERY: begin
						ram_re    = 1'b1;
						ram_raddr = id_slot;
						state_d   = ST_QWAIT;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_QWAIT: begin
				if (can_push) begin
					push.valid     = 1'b1;
					push.data.kind = KIND_QUERY;
					if (id_live) begin
						push.data.result_id    = id_q;
						push.data.remaining_us = ram_rdata.remaining;
						push.data.ok           = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (!stall_s1) begin
					if (s1_live) begin
						if (is_tick) begin
							if (expire) begin
								live_d[idx_s1] = 1'b0;
								if (pend_vld_q) begin
									push.valid             = 1'b1;
									push.data.kind         = KIND_EXPIRY;
									push.data.result_id    = ID_BITS'(pend_idx_q) + ID_BITS'(1);
									push.data.result_owner = 8'(pend_owner_q);
									push.data.ok           = 1'b1;
									push.data.last         = 1'b0;
								end
								pend_vld_d   = 1'b1;
								pend_idx_d   = idx_s1;
								pend_owner_d = ram_rdata.owner;
							end else begin
								ram_we              = 1'b1;
								ram_waddr           = idx_s1;
								ram_wdata.owner     = ram_rdata.owner;
								ram_wdata.remaining = ram_rdata.remaining - elapsed_q;
							end
						end else if (ram_rdata.owner == owner_q) begin
							live_d[idx_s1] = 1'b0;
							hit_d          = 1'b1;
						end
					end
					if (rd_idx_q != CNT_BITS'(SLOTS)) begin
						ram_re    = 1'b1;
						ram_raddr = rd_idx_q[SLOT_BITS-1:0];
						vld_s1_d  = 1'b1;
						idx_s1_d  = rd_idx_q[SLOT_BITS-1:0];
						rd_idx_d  = rd_idx_q + CNT_BITS'(1);
					end else begin
						vld_s1_d = 1'b0;
						if (!vld_s1) begin
							state_d = ST_FIN;
						end
					end
				end
			end
			ST_FIN: begin
				if (is_tick) begin
					if (!pend_vld_q) begin
						state_d = ST_IDLE;
					end else if (can_push) begin
						push.valid             = 1'b1;
						push.data.kind         = KIND_EXPIRY;
						push.data.result_id    = ID_BITS'(pend_idx_q) + ID_BITS'(1);
						push.data.result_owner = 8'(pend_owner_q);
						push.data.ok           = 1'b1;
						pend_vld_d             = 1'b0;
						state_d                = ST_IDLE;
					end
				end else if (can_push) begin
					push.valid     = 1'b1;
					push.data.kind = KIND_STOP_OWNER;
					push.data.ok   = hit_q;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			live_q     <= '0;
			rd_idx_q   <= '0;
			vld_s1     <= 1'b0;
			pend_vld_q <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			live_q     <= live_d;
			rd_idx_q   <= rd_idx_d;
			vld_s1     <= vld_s1_d;
			pend_vld_q <= pend_vld_d;
			hit_q      <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1       <= idx_s1_d;
		pend_idx_q   <= pend_idx_d;
		pend_owner_q <= pend_owner_d;
		if (accept) begin
			cmd_q      <= cmd.command;
			owner_q    <= cmd.owner[OWNER_BITS-1:0];
			duration_q <= cmd.duration_us;
			id_q       <= cmd.timer_id;
			elapsed_q  <= cmd.elapsed_us;
		end
	end

	stb_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	stb_rsp_reg u_rsp (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.can_push  (can_push),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/stb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/stb_rsp_reg.sv
// ----------------------------------------------------------------------------
// Timer bank result register
// Holds one result for the consumer; frees the sequencer while it waits.
// ----------------------------------------------------------------------------
module stb_rsp_reg import stb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rsp_push_t push,
	output logic      can_push,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_t      rsp
);

	logic vld_q;
	rsp_t data_q;

	assign can_push  = !vld_q || !rsp_stall;
	assign rsp_valid = vld_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (can_push) begin
			vld_q <= push.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push.valid) begin
			data_q <= push.data;
		end
	end

endmodule

FILE: rtl/stb_checker.sv
// ----------------------------------------------------------------------------
// Timer bank checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "software_timer_bank_unit_macros.svh"

module stb_checker import stb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic single_kind;
	logic is_expiry;
	logic expiry_good;
	logic id_match;

	// answers that carry an id: success exactly when an id is given
	assign single_kind = (rsp.kind == KIND_START) || (rsp.kind == KIND_STOP)
		|| (rsp.kind == KIND_QUERY);
	assign is_expiry   = rsp_valid && (rsp.kind == KIND_EXPIRY);
	assign expiry_good = rsp.ok && (rsp.result_id != '0)
		&& (32'(rsp.result_id) <= 32'(SLOTS));
	assign id_match    = (rsp.ok == (rsp.result_id != '0));

	`STB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result")
	`STB_ASSERT_NOW(a_expiry_ok, is_expiry, expiry_good, "bad expiry result")
	`STB_ASSERT_NOW(a_id_ok, rsp_valid && single_kind, id_match, "ok and id disagree")
	`STB_ASSERT_NOW(a_single_last, rsp_valid && !is_expiry, rsp.last, "answer not marked last")
	`STB_ASSERT_NOW(a_busy_stall, rsp_valid && !rsp.last, cmd_stall, "request inside a burst")

endmodule

bind software_timer_bank_unit stb_checker u_stb_checker (.*);

FILE: tb/software_timer_bank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank checker
// Watches both channels, keeps its own copy of the slot bank, predicts the
// results of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module software_timer_bank_checker import stb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fails,
	output int   pending,
	output int   checked
);

	localparam int SHOW_MAX = 30;

	logic                 live    [SLOTS];
	logic [7:0]           holder  [SLOTS];
	logic [TIME_BITS-1:0] left_us [SLOTS];

	rsp_t answers_due [$];
	int   fail_n = 0;
	int   seen_n = 0;

	function automatic rsp_t make_answer(logic [2:0] kind, int id, logic [7:0] own,
			logic [TIME_BITS-1:0] rem, logic ok, logic last);
		rsp_t r;
		r.kind         = kind;
		r.result_id    = ID_BITS'(id);
		r.result_owner = own;
		r.remaining_us = rem;
		r.ok           = ok;
		r.last         = last;
		return r;
	endfunction

	task automatic apply_request(input cmd_t c);
		rsp_t held;
		logic have;
		logic hit;
		int   slot;
		int   tid;
		int   i;
		have = 1'b0;
		hit  = 1'b0;
		slot = -1;
		tid  = int'(c.timer_id);
		case (c.command)
			CMD_START: begin
				for (i = SLOTS - 1; i >= 0; i--)
					if (!live[i])
						slot = i;
				if (slot < 0) begin
					answers_due.push_back(make_answer(KIND_START, 0, '0, '0, 1'b0, 1'b1));
				end else begin
					live[slot]    = 1'b1;
					holder[slot]  = c.owner;
					left_us[slot] = c.duration_us;
					answers_due.push_back(make_answer(KIND_START, slot + 1, '0, '0, 1'b1, 1'b1));
				end
			end
			CMD_TICK: begin
				// expiries go out in id order; only the final one carries last
				for (i = 0; i < SLOTS; i++) begin
					if (live[i]) begin
						if (left_us[i] <= c.elapsed_us) begin
							live[i]    = 1'b0;
							left_us[i] = '0;
							if (have)
								answers_due.push_back(held);
							held = make_answer(KIND_EXPIRY, i + 1, holder[i], '0, 1'b1, 1'b0);
							have = 1'b1;
						end else begin
							left_us[i] = left_us[i] - c.elapsed_us;
						end
					end
				end
				if (have) begin
					held.last = 1'b1;
					answers_due.push_back(held);
				end
			end
			CMD_STOP: begin
				if (tid >= 1 && tid <= SLOTS && live[tid - 1]) begin
					live[tid - 1] = 1'b0;
					answers_due.push_back(make_answer(KIND_STOP, tid, '0, '0, 1'b1, 1'b1));
				end else begin
					answers_due.push_back(make_answer(KIND_STOP, 0, '0, '0, 1'b0, 1'b1));
				end
			end
			CMD_STOP_OWNER: begin
				for (i = 0; i < SLOTS; i++) begin
					if (live[i] && holder[i] == c.owner) begin
						live[i] = 1'b0;
						hit     = 1'b1;
					end
				end
				answers_due.push_back(make_answer(KIND_STOP_OWNER, 0, '0, '0, hit, 1'b1));
			end
			CMD_QUERY: begin
				if (tid >= 1 && tid <= SLOTS && live[tid - 1])
					answers_due.push_back(make_answer(KIND_QUERY, tid, '0, left_us[tid - 1],
						1'b1, 1'b1));
				else
					answers_due.push_back(make_answer(KIND_QUERY, 0, '0, '0, 1'b0, 1'b1));
			end
			default: ;
		endcase
	endtask

	task automatic check_answer(input rsp_t got);
		rsp_t want;
		if (answers_due.size() == 0) begin
			fail_n++;
			if (fail_n <= SHOW_MAX)
				$display("%0t: unexpected result, expected none, got kind=%0d id=%0d own=%0d rem=%0d ok=%0b last=%0b",
					$time, got.kind, got.result_id, got.result_owner, got.remaining_us,
					got.ok, got.last);
		end else begin
			want = answers_due.pop_front();
			seen_n++;
			if (got !== want) begin
				fail_n++;
				if (fail_n <= SHOW_MAX)
					$display("%0t: result mismatch, expected kind=%0d id=%0d own=%0d rem=%0d ok=%0b last=%0b, got kind=%0d id=%0d own=%0d rem=%0d ok=%0b last=%0b",
						$time, want.kind, want.result_id, want.result_owner,
						want.remaining_us, want.ok, want.last, got.kind, got.result_id,
						got.result_owner, got.remaining_us, got.ok, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (live[i])
				live[i] = 1'b0;
			answers_due.delete();
			fails   <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// requests first: a result seen at this edge always belongs to an older request
			if (cmd_valid && !cmd_stall)
				apply_request(cmd);
			if (rsp_valid && !rsp_stall)
				check_answer(rsp);
			fails   <= fail_n;
			pending <= answers_due.size();
			checked <= seen_n;
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank testbench top
// Drives directed and random requests into the timer bank under shifting
// sender and receiver back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import stb_pkg::*;

	localparam int ITEMS       = 430;
	localparam int TAIL_CYCLES = 4 * SLOTS + 16;
	localparam int QUIET_LIMIT = 5000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int answers_pending;
	int answers_checked;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int sent_by_cmd [8];
	int sent_total  = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	software_timer_bank_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	software_timer_bank_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.fails     (fail_count),
		.pending   (answers_pending),
		.checked   (answers_checked)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no traffic for %0d cycles", $time, QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic cmd_t build(logic [2:0] op, logic [7:0] own, logic [TIME_BITS-1:0] dur,
			logic [ID_BITS-1:0] id, logic [TIME_BITS-1:0] delta);
		cmd_t c;
		c.command     = op;
		c.owner       = own;
		c.duration_us = dur;
		c.timer_id    = id;
		c.elapsed_us  = delta;
		return c;
	endfunction

	// a small owner pool makes owner-wide stops hit most of the time
	function automatic logic [7:0] pick_owner();
		if ($urandom_range(0, 99) < 75)
			return 8'($urandom_range(0, 5));
		return 8'($urandom);
	endfunction

	function automatic logic [ID_BITS-1:0] pick_id();
		if ($urandom_range(0, 99) < 85)
			return ID_BITS'($urandom_range(1, SLOTS));
		return ID_BITS'($urandom);
	endfunction

	function automatic cmd_t pick_request();
		cmd_t c;
		int   r;
		int   w;
		c = build(3'($urandom), 8'($urandom), $urandom, ID_BITS'($urandom), $urandom);
		r = $urandom_range(0, 99);
		w = $urandom_range(0, 99);
		if (r < 30) begin
			c.command = CMD_START;
			c.owner   = pick_owner();
			if (w < 60)
				c.duration_us = $urandom_range(0, 600);
			else if (w < 85)
				c.duration_us = $urandom_range(0, 60000);
		end else if (r < 52) begin
			c.command = CMD_TICK;
			if (w < 70)
				c.elapsed_us = $urandom_range(0, 250);
			else if (w < 85)
				c.elapsed_us = '0;
		end else if (r < 66) begin
			c.command  = CMD_STOP;
			c.timer_id = pick_id();
		end else if (r < 74) begin
			c.command = CMD_STOP_OWNER;
			c.owner   = pick_owner();
		end else if (r < 92) begin
			c.command  = CMD_QUERY;
			c.timer_id = pick_id();
		end else begin
			c.command = CMD_QUERY + 3'($urandom_range(1, 3));
		end
		return c;
	endfunction

	task automatic send(input cmd_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= item;
		do @(posedge clk); while (cmd_stall);
		sent_by_cmd[item.command]++;
		sent_total++;
	endtask

	// hold off new requests until every predicted result has arrived
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (answers_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		cmd_t item;
		int   real_items;
		int   phase;
		int   next_phase;
		int   k;

		foreach (sent_by_cmd[i])
			sent_by_cmd[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 31;
		recv_stall_pct <= 63;

		// fill the bank: zero and maximal durations, extreme owners, then one too many
		send(build(CMD_START, 8'h00, '0, '0, '0));
		send(build(CMD_START, 8'hFF, '1, '0, '0));
		for (k = 3; k <= SLOTS; k++)
			send(build(CMD_START, 8'(k % 4 + 1), TIME_BITS'(100 * k), '0, '0));
		send(build(CMD_START, 8'h09, 32'd77, '0, '0));
		send(build(CMD_QUERY, '0, '0, ID_BITS'(2), '0));
		send(build(CMD_QUERY, '0, '0, '0, '0));
		send(build(CMD_QUERY, '0, '0, ID_BITS'(SLOTS + 1), '0));
		send(build(CMD_STOP, '0, '0, '1, '0));
		send(build(CMD_STOP, '0, '0, '0, '0));
		send(build(CMD_QUERY + 3'd3, '1, '1, '1, '1));
		// zero elapsed still frees the zero-duration timer
		send(build(CMD_TICK, '0, '0, '0, '0));
		send(build(CMD_STOP, '0, '0, ID_BITS'(1), '0));
		send(build(CMD_STOP_OWNER, 8'd200, '0, '0, '0));
		send(build(CMD_STOP_OWNER, 8'd1, '0, '0, '0));
		// maximal elapsed frees every remaining timer in one sweep
		send(build(CMD_TICK, '0, '0, '0, '1));
		send(build(CMD_QUERY, '0, '0, ID_BITS'(3), '0));
		drain();

		real_items = 0;
		phase      = 0;
		while (real_items < ITEMS) begin
			next_phase = real_items * 3 / ITEMS;
			if (next_phase != phase) begin
				phase = next_phase;
				drain();
				if (phase == 1) begin
					send_idle_pct = 63;
					recv_stall_pct <= 31;
				end else begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
			end
			item = pick_request();
			send(item);
			real_items++;
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d start, %0d tick, %0d stop, %0d owner stop, %0d query",
			sent_total, sent_by_cmd[CMD_START], sent_by_cmd[CMD_TICK], sent_by_cmd[CMD_STOP],
			sent_by_cmd[CMD_STOP_OWNER], sent_by_cmd[CMD_QUERY]);
		$display("%0d results compared under three back-pressure mixes, %0d failures",
			answers_checked, fail_count);
		if (fail_count == 0 && answers_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/stb_pkg.sv
rtl/stb_ram.sv
rtl/stb_rsp_reg.sv
rtl/software_timer_bank_unit.sv
rtl/stb_checker.sv
tb/software_timer_bank_checker.sv
tb/tb_top.sv
